// ----- src/smi_pkg.sv -----
// Shared types and constants for the small matrix inverse core.
// Holds the back-end state type, the cofactor operand table and the queue control struct.
// No dependencies.
package smi_pkg;

  // Number of matrix entries carried by one beat.
  localparam int NUM_ENTRIES = 9;
  // Multiply steps: two per cofactor, then two per determinant term.
  localparam int NUM_COF_STEPS = 18;
  localparam int NUM_STEPS = 24;

  // Operand select: 0..8 picks a matrix entry, the rest pick constants.
  typedef logic [3:0] sel_t;
  localparam sel_t SEL_ONE  = 4'd9;
  localparam sel_t SEL_ZERO = 4'd10;

  // Matrix entry positions, row-major.
  localparam sel_t E00 = 4'd0;
  localparam sel_t E01 = 4'd1;
  localparam sel_t E02 = 4'd2;
  localparam sel_t E10 = 4'd3;
  localparam sel_t E11 = 4'd4;
  localparam sel_t E12 = 4'd5;
  localparam sel_t E20 = 4'd6;
  localparam sel_t E21 = 4'd7;
  localparam sel_t E22 = 4'd8;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_SING,
    BK_DIV_INIT,
    BK_DIV_CHK,
    BK_DIV_STEP,
    BK_DIV_END,
    BK_DONE
  } bk_state_e;

  // One cofactor is neg ? -(p*q - r*s) : (p*q - r*s).
  typedef struct packed {
    sel_t p;
    sel_t q;
    sel_t r;
    sel_t s;
    logic neg;
  } cof_op_t;

  // Control that travels with the head of the queue.
  typedef struct packed {
    logic valid;
    logic two;
  } item_ctrl_t;

  // Operand table for cofactor k (row-major over the adjugate).
  function automatic cof_op_t cof_op(logic two, logic [3:0] k);
    cof_op_t op;
    op = '{p: SEL_ZERO, q: SEL_ZERO, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b0};
    if (two) begin
      case (k)
        4'd0: op = '{p: E11, q: SEL_ONE, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b0};
        4'd1: op = '{p: E01, q: SEL_ONE, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b1};
        4'd3: op = '{p: E10, q: SEL_ONE, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b1};
        4'd4: op = '{p: E00, q: SEL_ONE, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b0};
        default: op = '{p: SEL_ZERO, q: SEL_ZERO, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b0};
      endcase
    end else begin
      case (k)
        4'd0: op = '{p: E22, q: E11, r: E21, s: E12, neg: 1'b0};
        4'd1: op = '{p: E22, q: E01, r: E21, s: E02, neg: 1'b1};
        4'd2: op = '{p: E12, q: E01, r: E11, s: E02, neg: 1'b0};
        4'd3: op = '{p: E22, q: E10, r: E20, s: E12, neg: 1'b1};
        4'd4: op = '{p: E22, q: E00, r: E20, s: E02, neg: 1'b0};
        4'd5: op = '{p: E12, q: E00, r: E10, s: E02, neg: 1'b1};
        4'd6: op = '{p: E21, q: E10, r: E20, s: E11, neg: 1'b0};
        4'd7: op = '{p: E21, q: E00, r: E20, s: E01, neg: 1'b1};
        4'd8: op = '{p: E11, q: E00, r: E10, s: E01, neg: 1'b0};
        default: op = '{p: SEL_ZERO, q: SEL_ZERO, r: SEL_ZERO, s: SEL_ZERO, neg: 1'b0};
      endcase
    end
    return op;
  endfunction

endpackage

// ----- src/small_matrix_inverse_core.sv -----
// Top level of the small matrix inverse core (2x2 or 3x3, signed fixed point).
// Depends on smi_pkg, smi_front and smi_back.
//
// Channel   | Direction | Handshake                  | Beat
// ----------+-----------+----------------------------+-------------------------------
// command   | in        | start high, busy low       | a00_i .. a22_i
// config    | in        | cfg_valid_i & cfg_ready_o  | cfg_data_i (matrix size)
// result    | out       | done_o, one cycle          | b00_o .. b22_o, determinant_o,
//           |           |                            | singular_o
//
// In the back end, the shared multiplier forms 24 products in turn and the restoring divider
// yields one quotient bit per cycle for each of the nine inverse entries. A singular matrix
// finishes after the multiply phase. A two-entry queue takes commands while the back end
// works; busy is high only while both slots are full. Reset clears the queue and the
// sequencer and sets the matrix size to 3. The receiver cannot stall; done_o lasts one cycle.
module small_matrix_inverse_core import smi_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ENTRY_WIDTH-1:0] a00_i,
  input  logic signed [ENTRY_WIDTH-1:0] a01_i,
  input  logic signed [ENTRY_WIDTH-1:0] a02_i,
  input  logic signed [ENTRY_WIDTH-1:0] a10_i,
  input  logic signed [ENTRY_WIDTH-1:0] a11_i,
  input  logic signed [ENTRY_WIDTH-1:0] a12_i,
  input  logic signed [ENTRY_WIDTH-1:0] a20_i,
  input  logic signed [ENTRY_WIDTH-1:0] a21_i,
  input  logic signed [ENTRY_WIDTH-1:0] a22_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  output logic                          done_o,
  output logic signed [ENTRY_WIDTH-1:0] b00_o,
  output logic signed [ENTRY_WIDTH-1:0] b01_o,
  output logic signed [ENTRY_WIDTH-1:0] b02_o,
  output logic signed [ENTRY_WIDTH-1:0] b10_o,
  output logic signed [ENTRY_WIDTH-1:0] b11_o,
  output logic signed [ENTRY_WIDTH-1:0] b12_o,
  output logic signed [ENTRY_WIDTH-1:0] b20_o,
  output logic signed [ENTRY_WIDTH-1:0] b21_o,
  output logic signed [ENTRY_WIDTH-1:0] b22_o,
  output logic signed [ENTRY_WIDTH-1:0] determinant_o,
  output logic                          singular_o
);

  logic signed [ENTRY_WIDTH-1:0] a_in  [NUM_ENTRIES];
  logic signed [ENTRY_WIDTH-1:0] a_q2b [NUM_ENTRIES];
  logic signed [ENTRY_WIDTH-1:0] b_out [NUM_ENTRIES];
  item_ctrl_t                    head_ctrl;
  logic                          pop;

  // Gather the matrix entries, row-major.
  assign a_in[E00] = a00_i;
  assign a_in[E01] = a01_i;
  assign a_in[E02] = a02_i;
  assign a_in[E10] = a10_i;
  assign a_in[E11] = a11_i;
  assign a_in[E12] = a12_i;
  assign a_in[E20] = a20_i;
  assign a_in[E21] = a21_i;
  assign a_in[E22] = a22_i;

  // Command accept and item queue.
  smi_front #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .a_i        (a_in),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctrl_o     (head_ctrl),
    .a_o        (a_q2b),
    .pop_i      (pop)
  );

  // Cofactors, determinant and division.
  smi_back #(
    .ENTRY_WIDTH(ENTRY_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(head_ctrl),
    .a_i   (a_q2b),
    .pop_o (pop),
    .b_o   (b_out),
    .det_o (determinant_o),
    .sing_o(singular_o),
    .done_o(done_o)
  );

  // Spread the inverse entries onto their ports.
  assign b00_o = b_out[E00];
  assign b01_o = b_out[E01];
  assign b02_o = b_out[E02];
  assign b10_o = b_out[E10];
  assign b11_o = b_out[E11];
  assign b12_o = b_out[E12];
  assign b20_o = b_out[E20];
  assign b21_o = b_out[E21];
  assign b22_o = b_out[E22];

endmodule

// ----- src/smi_front.sv -----
// Front end of the small matrix inverse core: command accept, size register, item queue.
// Depends on smi_pkg.
module smi_front import smi_pkg::*; #(
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ENTRY_WIDTH-1:0] a_i [NUM_ENTRIES],
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  output item_ctrl_t                    ctrl_o,
  output logic signed [ENTRY_WIDTH-1:0] a_o [NUM_ENTRIES],
  input  logic                          pop_i
);

  localparam int QDEPTH = 2;
  localparam logic [1:0] SIZE_TWO = 2'd2;
  localparam logic [1:0] SIZE_RESET = 2'd3;

  logic [1:0] size_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  logic signed [ENTRY_WIDTH-1:0] ent_q [QDEPTH][NUM_ENTRIES];
  logic                          two_q [QDEPTH];

  // The size register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // Queue handshake: accept while a slot is free, pop when the back end asks.
  assign busy   = (cnt_q == 2'(QDEPTH));
  assign push   = start && !busy;
  assign pop    = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Queue storage; the size mode is classified at accept time.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= a_i;
      two_q[wr_ptr_q] <= (size_q == SIZE_TWO);
    end
  end

  // Head of the queue toward the back end.
  assign a_o          = ent_q[rd_ptr_q];
  assign ctrl_o.valid = (cnt_q != 2'd0);
  assign ctrl_o.two   = two_q[rd_ptr_q];

endmodule

// ----- src/smi_back.sv -----
// Back end of the small matrix inverse core: shared multiplier sequencer and restoring divider.
// Depends on smi_pkg.
module smi_back import smi_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  item_ctrl_t                    ctrl_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_i [NUM_ENTRIES],
  output logic                          pop_o,
  output logic signed [ENTRY_WIDTH-1:0] b_o [NUM_ENTRIES],
  output logic signed [ENTRY_WIDTH-1:0] det_o,
  output logic                          sing_o,
  output logic                          done_o
);

  localparam int W    = ENTRY_WIDTH;
  localparam int PW   = 2 * W + 2;
  localparam int CFW  = 2 * W + 1;
  localparam int DETW = 3 * W + 1;
  localparam int NUMW = CFW + 2 * FRAC_BITS;
  localparam int DSW  = DETW + W;
  localparam int CW   = (NUMW > DSW) ? NUMW : DSW;
  localparam int BITW = $clog2(W);

  bk_state_e state_q, state_d;

  logic [4:0]      step_q;
  logic [3:0]      k_q;
  logic [BITW-1:0] bit_q;
  logic            done_q;
  logic            load_out;

  logic signed [W-1:0]    a_q    [NUM_ENTRIES];
  logic                   two_q;
  logic signed [CFW-1:0]  cof_q  [NUM_ENTRIES];
  logic signed [PW-1:0]   acc_q, prod_q, prod_d;
  logic signed [DETW-1:0] det_q;
  logic [CW-1:0]          rem_q, dsh_q;
  logic [W-1:0]           quo_q;
  logic                   ovf_q;
  logic [W-1:0]           bres_q [NUM_ENTRIES];
  logic [W-1:0]           bout_q [NUM_ENTRIES];
  logic [W-1:0]           dout_q;
  logic                   sing_q;

  logic                   is_cof;
  logic [3:0]             kc;
  cof_op_t                op;
  logic [4:0]             dstep;
  logic [1:0]             di;
  logic signed [W-1:0]    dent;
  logic signed [CFW-1:0]  dcof;
  logic signed [W:0]      ma, mb;
  logic signed [PW-1:0]   diff, cofnew;
  logic signed [CFW-1:0]  cs;
  logic [CFW-1:0]         cm;
  logic [DETW-1:0]        dm, dshifted, qm;
  logic                   qneg;

  // Entry or constant operand for the multiplier.
  function automatic logic signed [W:0] pick(sel_t s, logic signed [W-1:0] e [NUM_ENTRIES]);
    logic signed [W:0] v;
    v = '0;
    case (s)
      SEL_ONE:  v = (W+1)'(1);
      SEL_ZERO: v = '0;
      default: begin
        if (s < sel_t'(NUM_ENTRIES)) begin
          v = (W+1)'(e[s]);
        end
      end
    endcase
    return v;
  endfunction

  // Saturate a magnitude with a sign to the signed entry range.
  function automatic logic [W-1:0] sat(logic [DETW-1:0] m, logic neg);
    logic [DETW-1:0] lim;
    logic [DETW-1:0] nm;
    logic [W-1:0]    r;
    lim = DETW'(1) << (W - 1);
    nm  = -m;
    if (!neg) begin
      r = (m >= lim) ? (lim[W-1:0] - W'(1)) : m[W-1:0];
    end else begin
      r = (m > lim) ? lim[W-1:0] : nm[W-1:0];
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    is_cof = (step_q < 5'(NUM_COF_STEPS));
    kc     = step_q[4:1];
    op     = cof_op(two_q, kc);
    dstep  = step_q - 5'(NUM_COF_STEPS);
    di     = dstep[2:1];
    case (di)
      2'd0:    dent = a_q[E00];
      2'd1:    dent = a_q[E10];
      default: dent = a_q[E20];
    endcase
    dcof = cof_q[{2'b00, di}];
    if (is_cof) begin
      ma = pick(step_q[0] ? op.r : op.p, a_q);
      mb = pick(step_q[0] ? op.s : op.q, a_q);
    end else begin
      ma = (W+1)'(dent);
      mb = step_q[0] ? dcof[CFW-1:W] : {1'b0, dcof[W-1:0]};
    end
    prod_d = ma * mb;
  end

  // Cofactor finish, magnitudes and divider result.
  always_comb begin
    diff     = acc_q - prod_q;
    cofnew   = op.neg ? -diff : diff;
    cs       = cof_q[k_q];
    cm       = cs[CFW-1] ? CFW'(-cs) : CFW'(cs);
    dm       = det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
    dshifted = two_q ? (dm >> FRAC_BITS) : (dm >> (2 * FRAC_BITS));
    qneg     = cs[CFW-1] ^ det_q[DETW-1];
    qm       = ovf_q ? {DETW{1'b1}} : DETW'(quo_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:     if (ctrl_i.valid) state_d = BK_MUL;
      BK_MUL:      state_d = BK_ACC;
      BK_ACC:      state_d = (step_q == 5'(NUM_STEPS - 1)) ? BK_SING : BK_MUL;
      BK_SING:     state_d = (det_q == '0) ? BK_DONE : BK_DIV_INIT;
      BK_DIV_INIT: state_d = BK_DIV_CHK;
      BK_DIV_CHK:  state_d = BK_DIV_STEP;
      BK_DIV_STEP: if (bit_q == BITW'(W - 1)) state_d = BK_DIV_END;
      BK_DIV_END:  state_d = (k_q == 4'(NUM_ENTRIES - 1)) ? BK_DONE : BK_DIV_INIT;
      BK_DONE:     state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = ctrl_i.valid;
      BK_DONE: load_out = 1'b1;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
      k_q     <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= load_out;
      if (pop_o) begin
        step_q <= '0;
        k_q    <= '0;
      end
      if (state_q == BK_ACC) begin
        step_q <= step_q + 5'd1;
      end
      if (state_q == BK_DIV_END) begin
        k_q <= k_q + 4'd1;
      end
      if (state_q == BK_DIV_CHK) begin
        bit_q <= '0;
      end else if (state_q == BK_DIV_STEP) begin
        bit_q <= bit_q + BITW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (ctrl_i.valid) begin
          a_q   <= a_i;
          two_q <= ctrl_i.two;
          det_q <= '0;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            bres_q[i] <= '0;
          end
        end
      end
      BK_MUL: prod_q <= prod_d;
      BK_ACC: begin
        if (is_cof) begin
          if (!step_q[0]) begin
            acc_q <= prod_q;
          end else begin
            cof_q[kc] <= cofnew[CFW-1:0];
          end
        end else if (!step_q[0]) begin
          det_q <= det_q + DETW'(prod_q);
        end else begin
          det_q <= det_q + (DETW'(prod_q) <<< W);
        end
      end
      BK_DIV_INIT: begin
        rem_q <= CW'(cm) << (2 * FRAC_BITS);
        dsh_q <= CW'(dm) << W;
        quo_q <= '0;
      end
      BK_DIV_CHK: begin
        ovf_q <= (rem_q >= dsh_q);
        dsh_q <= dsh_q >> 1;
      end
      BK_DIV_STEP: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      BK_DIV_END: bres_q[k_q] <= sat(qm, qneg);
      BK_DONE: begin
        bout_q <= bres_q;
        dout_q <= sat(dshifted, det_q[DETW-1]);
        sing_q <= (det_q == '0);
      end
      default: begin
      end
    endcase
  end

  // Result beat.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      b_o[i] = bout_q[i];
    end
  end
  assign det_o  = dout_q;
  assign sing_o = sing_q;
  assign done_o = done_q;

endmodule

// ----- tb/smi_checker.sv -----
// Scoreboard for the small matrix inverse core: predicts each result from the command beats.
// It watches the command, configuration and result ports of the core.
// Depends on nothing but the core's port widths.
module smi_checker #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [8:0][ENTRY_WIDTH-1:0]   mat_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  input  logic                          done_o,
  input  logic [8:0][ENTRY_WIDTH-1:0]   inv_o,
  input  logic [ENTRY_WIDTH-1:0]        determinant_o,
  input  logic                          singular_o,
  output int                            pending_o,
  output int                            fail_count_o
);

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [8:0][ENTRY_WIDTH-1:0] inv;
    logic [ENTRY_WIDTH-1:0]      det;
    logic                        sing;
  } inverse_t;

  inverse_t   inverse_q[$];
  logic [1:0] size_q;
  int         fails;

  assign pending_o    = inverse_q.size();
  assign fail_count_o = fails;

  // Clamp a wide value to the signed entry range.
  function automatic logic [ENTRY_WIDTH-1:0] clamp(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (ENTRY_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (ENTRY_WIDTH - 1));
    if (v > hi) return hi[ENTRY_WIDTH-1:0];
    if (v < lo) return lo[ENTRY_WIDTH-1:0];
    return v[ENTRY_WIDTH-1:0];
  endfunction

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Exact adjugate and determinant, then truncating division and saturation.
  function automatic inverse_t invert(logic [8:0][ENTRY_WIDTH-1:0] m, logic two);
    wide_t    a[9];
    wide_t    adj[9];
    wide_t    det;
    wide_t    q;
    int       shift;
    inverse_t res;
    for (int i = 0; i < 9; i++) begin
      a[i]   = wide_t'($signed(m[i]));
      adj[i] = 0;
    end
    if (two) begin
      adj[0] = a[4];
      adj[1] = -a[1];
      adj[3] = -a[3];
      adj[4] = a[0];
      det    = a[0] * a[4] - a[1] * a[3];
      shift  = FRAC_BITS;
    end else begin
      adj[0] = a[8] * a[4] - a[7] * a[5];
      adj[1] = -(a[8] * a[1] - a[7] * a[2]);
      adj[2] = a[5] * a[1] - a[4] * a[2];
      adj[3] = -(a[8] * a[3] - a[6] * a[5]);
      adj[4] = a[8] * a[0] - a[6] * a[2];
      adj[5] = -(a[5] * a[0] - a[3] * a[2]);
      adj[6] = a[7] * a[3] - a[6] * a[4];
      adj[7] = -(a[7] * a[0] - a[6] * a[1]);
      adj[8] = a[4] * a[0] - a[3] * a[1];
      det    = a[0] * adj[0] + a[3] * adj[1] + a[6] * adj[2];
      shift  = 2 * FRAC_BITS;
    end
    res.sing = (det == 0);
    for (int i = 0; i < 9; i++) begin
      res.inv[i] = '0;
      if (!res.sing && !(two && (i % 3 == 2 || i / 3 == 2))) begin
        q = wide_t'(unsigned'(mag(adj[i]) <<< (2 * FRAC_BITS)) / unsigned'(mag(det)));
        if ((adj[i] < 0) != (det < 0)) q = -q;
        res.inv[i] = clamp(q);
      end
    end
    q       = mag(det) >>> shift;
    res.det = clamp((det < 0) ? -q : q);
    return res;
  endfunction

  // Compare finished results with the oldest prediction, then log new commands.
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      size_q = 2'd3;
      fails  = 0;
      inverse_q.delete();
    end else begin
      if (done_o) begin
        if (inverse_q.size() == 0) begin
          $error("result beat with no matrix outstanding");
          fails++;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (inv_o[i] !== want.inv[i]) begin
              $error("b%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                     $signed(want.inv[i]), $signed(inv_o[i]));
              fails++;
            end
          end
          if (determinant_o !== want.det) begin
            $error("determinant: expected %0d, got %0d", $signed(want.det),
                   $signed(determinant_o));
            fails++;
          end
          if (singular_o !== want.sing) begin
            $error("singular: expected %0b, got %0b", want.sing, singular_o);
            fails++;
          end
        end
      end
      if (start && !busy) inverse_q.push_back(invert(mat_i, size_q == 2'd2));
      if (cfg_valid_i && cfg_ready_o) size_q = cfg_data_i;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the small matrix inverse testbench: clock, reset, command and configuration stimulus.
// Depends on small_matrix_inverse_core and the smi_checker scoreboard.
module tb_top;

  localparam int EW = 32;
  localparam int ONE = 32'h0001_0000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [8:0][EW-1:0]    mat;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_data_i;
  logic                  done_o;
  logic [8:0][EW-1:0]    inv;
  logic [EW-1:0]         determinant_o;
  logic                  singular_o;
  int                    pending;
  int                    fail_count;
  int                    sender_idle_pct;

  small_matrix_inverse_core dut (
    .clk_i, .rst_ni, .start, .busy,
    .a00_i(mat[0]), .a01_i(mat[1]), .a02_i(mat[2]),
    .a10_i(mat[3]), .a11_i(mat[4]), .a12_i(mat[5]),
    .a20_i(mat[6]), .a21_i(mat[7]), .a22_i(mat[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o,
    .b00_o(inv[0]), .b01_o(inv[1]), .b02_o(inv[2]),
    .b10_o(inv[3]), .b11_o(inv[4]), .b12_o(inv[5]),
    .b20_o(inv[6]), .b21_o(inv[7]), .b22_o(inv[8]),
    .determinant_o, .singular_o
  );

  smi_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .mat_i(mat), .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .inv_o(inv), .determinant_o, .singular_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard stop in case the core hangs.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Drive one matrix beat and hold it until the core takes it.
  task automatic send_matrix(input logic [8:0][EW-1:0] m);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    mat   = m;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Let every outstanding matrix finish, then write the size register.
  task automatic set_size(input logic [1:0] size);
    wait (pending == 0);
    repeat (400) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = size;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random matrix: full-range bits, modest values, or a singular one with a repeated row.
  function automatic logic [8:0][EW-1:0] random_matrix();
    logic [8:0][EW-1:0] m;
    int                 kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 3) m[i] = $urandom();
      else if (kind < 8) m[i] = $signed($urandom_range(2 * 4 * ONE)) - 4 * ONE;
      else m[i] = $signed($urandom_range(2 * 64)) - 64;
    end
    if (kind == 9 || $urandom_range(15) == 0) begin
      for (int c = 0; c < 3; c++) m[3 + c] = m[c];
    end
    return m;
  endfunction

  initial begin
    logic [8:0][EW-1:0] m;
    logic [1:0]         sizes[6];
    start           = 1'b0;
    mat             = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 2'd3;
    sender_idle_pct = 0;
    sizes           = '{2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    rst_ni          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: singular, identity with two corner entries set, tiny determinant, extremes, each size code.
    for (int pass = 0; pass < 4; pass++) begin
      if (pass > 0) set_size(pass == 1 ? 2'd2 : (pass == 2 ? 2'd0 : 2'd1));
      send_matrix('0);
      m = '0;
      m[0] = ONE; m[4] = ONE; m[8] = ONE;
      m[2] = 32'hDEAD_BEEF; m[6] = 32'h1234_5678;
      send_matrix(m);
      m = '0;
      m[0] = 1; m[4] = 1; m[8] = 1;
      send_matrix(m);
      send_matrix({9{32'h7FFF_FFFF}});
      m = {9{32'h8000_0000}};
      m[1] = 32'h7FFF_FFFF; m[5] = 32'h7FFF_FFFF;
      send_matrix(m);
      m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      send_matrix(m);
    end

    // Random phases: sender idles rarely, often, then never; size changes between.
    for (int ph = 0; ph < 6; ph++) begin
      set_size(sizes[ph]);
      sender_idle_pct = (ph < 2) ? 11 : ((ph < 4) ? 74 : 0);
      for (int n = 0; n < 120; n++) begin
        send_matrix(random_matrix());
        if ($urandom_range(99) == 0) wait (pending == 0);
      end
    end

    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
